>>> rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// shared widths, constants and inter-module structs of the keyframe sampler
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  localparam int TIME_W  = 24;
  localparam int COMP_W  = 32;
  localparam int VEC_W   = 3 * COMP_W;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int CNT_W   = 7;

  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << FRAC_W;
  localparam logic [RATIO_W-1:0] RATIO_ZERO = '0;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] key_time;
    logic [VEC_W-1:0]  key_value;
  } kts_wr_t;

  typedef struct packed {
    logic              start;
    logic              zero;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } kts_div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] ratio;
  } kts_div_res_t;

  typedef struct packed {
    logic               start;
    logic [RATIO_W-1:0] ratio;
    logic [VEC_W-1:0]   early;
    logic [VEC_W-1:0]   late;
  } kts_lerp_req_t;

  typedef struct packed {
    logic             done;
    logic [VEC_W-1:0] value;
  } kts_lerp_res_t;

endpackage

`default_nettype wire

>>> rtl/kts_store.sv
// ----------------------------------------------------------------------------
// kts_store
// keyframe time and value memories, one write port and one registered read
// port each
// ----------------------------------------------------------------------------
`default_nettype none

module kts_store import kts_pkg::*; #(
  parameter int KEYS  = 64,
  parameter int IDX_W = $clog2(KEYS)
) (
  input  wire logic              clk,
  input  wire kts_wr_t           wr,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [IDX_W-1:0]  t_rd_addr,
  input  wire logic [IDX_W-1:0]  v_rd_addr,
  output logic      [TIME_W-1:0] t_rd_data,
  output logic      [VEC_W-1:0]  v_rd_data
);

  logic [TIME_W-1:0] tmem [KEYS];
  logic [VEC_W-1:0]  vmem [KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tmem[wr_addr] <= wr.key_time;
      vmem[wr_addr] <= wr.key_value;
    end
    t_rd_data <= tmem[t_rd_addr];
    v_rd_data <= vmem[v_rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div
// iterative restoring divider for the q1.16 segment ratio, one quotient bit
// per cycle, saturating at one and returning zero on a zero request
// ----------------------------------------------------------------------------
`default_nettype none

module kts_div import kts_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire kts_div_req_t req,
  output kts_div_res_t      res
);

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den;
  logic [FRAC_W-1:0] quo;
  logic [TIME_W:0]   rem_sh;
  logic              take;

  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
      step     <= '0;
    end else begin
      if (req.start) begin
        if (req.zero) begin
          res.ratio <= RATIO_ZERO;
          res.done  <= 1'b1;
        end else if (req.num >= req.den) begin
          res.ratio <= RATIO_ONE;
          res.done  <= 1'b1;
        end else begin
          res.done <= 1'b0;
          busy     <= 1'b1;
          step     <= '0;
          rem      <= req.num;
          den      <= req.den;
        end
      end else if (busy) begin
        rem  <= take ? TIME_W'(rem_sh - {1'b0, den}) : rem_sh[TIME_W-1:0];
        quo  <= {quo[FRAC_W-2:0], take};
        step <= step + 1'b1;
        if (step == STEP_W'(FRAC_W - 1)) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.ratio <= {1'b0, quo[FRAC_W-2:0], take};
        end else begin
          res.done <= 1'b0;
        end
      end else begin
        res.done <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res.done |-> res.ratio <= RATIO_ONE)
    else $error("ratio above one");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> den > rem)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/kts_lerp.sv
// ----------------------------------------------------------------------------
// kts_lerp
// per-component blend early + ratio * (late - early), one shared multiplier
// stepped over the three components
// ----------------------------------------------------------------------------
`default_nettype none

module kts_lerp import kts_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kts_lerp_req_t req,
  output kts_lerp_res_t      res
);

  localparam int DIFF_W = COMP_W + 1;
  localparam int PROD_W = DIFF_W + RATIO_W + 1;

  logic                     busy;
  logic [2:0]               step;
  logic [RATIO_W-1:0]       ratio;
  logic signed [COMP_W-1:0] e_r [3];
  logic signed [COMP_W-1:0] l_r [3];
  logic signed [COMP_W-1:0] v_r [3];
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [1:0]               di;
  logic [1:0]               mi;
  logic [1:0]               ai;

  assign di = step[1:0];
  assign mi = 2'(step - 3'd1);
  assign ai = 2'(step - 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
      step     <= '0;
    end else begin
      if (req.start) begin
        res.done <= 1'b0;
        busy     <= 1'b1;
        step     <= '0;
        ratio    <= req.ratio;
        for (int c = 0; c < 3; c++) begin
          e_r[c] <= req.early[c*COMP_W +: COMP_W];
          l_r[c] <= req.late[c*COMP_W +: COMP_W];
        end
      end else if (busy) begin
        if (step < 3'd3) begin
          diff_r <= DIFF_W'(l_r[di]) - DIFF_W'(e_r[di]);
        end
        if (step >= 3'd1 && step <= 3'd3) begin
          prod_r <= $signed({1'b0, ratio}) * diff_r;
        end
        if (step >= 3'd2) begin
          v_r[ai] <= e_r[ai] + prod_r[FRAC_W +: COMP_W];
        end
        step <= step + 3'd1;
        if (step == 3'd4) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
        end else begin
          res.done <= 1'b0;
        end
      end else begin
        res.done <= 1'b0;
      end
    end
  end

  assign res.value = {v_r[2], v_r[1], v_r[0]};

  assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= 3'd4)
    else $error("blend step out of range");

  assert property (@(posedge clk) disable iff (rst)
    res.done |-> $past(busy) && !busy)
    else $error("blend done without a running blend");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("blend restarted while busy");

endmodule

`default_nettype wire

>>> rtl/keyframe_track_sampler_core.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core
// keyframe track with linear interpolation between the two keys around a
// query time
// ----------------------------------------------------------------------------
// channel   dir  handshake                   contents
// s_axis    in   s_axis_tvalid/tready        tuser: cmd, tdata: key write or query
// m_axis    out  m_axis_tvalid/tready        tdata: interpolated value x, y, z
// cfg       in   cfg_we                      cfg_wdata: key_count
//
// key write: taken whenever the block is idle
// sample ending on key k of n in use: a scan over the key times up to key k, two
// value reads, the divide, the blend and the output load, in that order
// ratio of zero or one skips the divide iterations; one key in use skips the scan
// rst is synchronous; memories hold no reset and are valid once written
// a finished sample waits while the output register is full, input closed
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_sampler_core import kts_pkg::*; #(
  parameter int KEYS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key_index, key_time, key_x, key_y, key_z, query_time, 2 unused bits
  input  wire logic [151:0] s_axis_tdata,
  // cmd
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // value_x, value_y, value_z
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(KEYS);
  localparam int CW    = ($clog2(KEYS + 1) > CNT_W) ? $clog2(KEYS + 1) : CNT_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_VAL_E  = 7'b0000100,
    ST_VAL_L  = 7'b0001000,
    ST_DIVIDE = 7'b0010000,
    ST_LERP   = 7'b0100000,
    ST_HOLD   = 7'b1000000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  key_count;
  logic [CW-1:0]     cnt_ext;
  logic [CW-1:0]     n_eff;
  logic [IDX_W-1:0]  last_a;
  logic [IDX_W-1:0]  scan_a;
  logic [TIME_W-1:0] q;
  logic [TIME_W-1:0] t0;
  logic [TIME_W-1:0] t1;
  logic              single;
  logic [VEC_W-1:0]  early;
  logic [VEC_W-1:0]  late;
  logic [RATIO_W-1:0] ratio;

  logic              s_fire;
  logic              cmd;
  logic [5:0]        in_index;
  logic [TIME_W-1:0] in_time;
  logic [VEC_W-1:0]  in_value;
  logic [TIME_W-1:0] in_query;
  logic              hit;

  kts_wr_t           wr;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  t_rd_addr;
  logic [IDX_W-1:0]  v_rd_addr;
  logic [TIME_W-1:0] t_rd_data;
  logic [VEC_W-1:0]  v_rd_data;
  kts_div_req_t      div_req;
  kts_div_res_t      div_res;
  kts_lerp_req_t     lerp_req;
  kts_lerp_res_t     lerp_res;

  assign cmd      = s_axis_tuser[0];
  assign in_index = s_axis_tdata[5:0];
  assign in_time  = s_axis_tdata[29:6];
  assign in_value = s_axis_tdata[125:30];
  assign in_query = s_axis_tdata[149:126];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign cnt_ext = CW'(key_count);
  assign n_eff   = (cnt_ext == '0) ? CW'(1) : (cnt_ext > CW'(KEYS)) ? CW'(KEYS) : cnt_ext;
  assign last_a  = IDX_W'(n_eff - CW'(1));
  assign hit     = (scan_a != '0) && ((q < t_rd_data) || (scan_a == last_a));

  assign wr.en        = s_fire && (cmd == CMD_WRITE) && (int'(in_index) < KEYS);
  assign wr.key_time  = in_time;
  assign wr.key_value = in_value;
  assign wr_addr      = IDX_W'(in_index);

  always_comb begin
    t_rd_addr = '0;
    v_rd_addr = '0;
    case (state)
      ST_SCAN:  begin
        t_rd_addr = scan_a + 1'b1;
        v_rd_addr = scan_a - 1'b1;
      end
      ST_VAL_E: v_rd_addr = scan_a;
      default:  ;
    endcase
  end

  kts_store #(.KEYS(KEYS), .IDX_W(IDX_W)) u_store (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .t_rd_addr (t_rd_addr),
    .v_rd_addr (v_rd_addr),
    .t_rd_data (t_rd_data),
    .v_rd_data (v_rd_data)
  );

  assign div_req.start = (state == ST_VAL_L) || ((state == ST_VAL_E) && single);
  assign div_req.zero  = single || (t1 <= t0) || (q <= t0);
  assign div_req.num   = q - t0;
  assign div_req.den   = t1 - t0;

  kts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  assign lerp_req.start = (state == ST_DIVIDE) && div_res.done;
  assign lerp_req.ratio = div_res.ratio;
  assign lerp_req.early = early;
  assign lerp_req.late  = late;

  kts_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lerp_req),
    .res (lerp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_HOLD)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire && (cmd == CMD_SAMPLE)) begin
            q      <= in_query;
            scan_a <= '0;
            single <= (n_eff == CW'(1));
            state  <= (n_eff == CW'(1)) ? ST_VAL_E : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            t1    <= t_rd_data;
            state <= ST_VAL_E;
          end else begin
            t0     <= t_rd_data;
            scan_a <= scan_a + 1'b1;
          end
        end
        ST_VAL_E: begin
          early <= v_rd_data;
          late  <= v_rd_data;
          state <= single ? ST_DIVIDE : ST_VAL_L;
        end
        ST_VAL_L: begin
          late  <= v_rd_data;
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_res.done) begin
            ratio <= div_res.ratio;
            state <= ST_LERP;
          end
        end
        ST_LERP: begin
          if (lerp_res.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= lerp_res.value;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_fire && (cmd == CMD_SAMPLE)) |=> (state == ST_SCAN || state == ST_VAL_E))
    else $error("sample transaction did not start a lookup");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> scan_a <= last_a)
    else $error("scan ran past the last key");

  assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIVIDE))
    else $error("ratio ready outside divide phase");

  assert property (@(posedge clk) disable iff (rst)
    lerp_res.done |-> (state == ST_LERP))
    else $error("blend ready outside blend phase");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LERP) |-> ratio <= RATIO_ONE)
    else $error("blend ratio above one");

endmodule

`default_nettype wire

>>> bench/tb_keyframe_track_sampler_core.sv
// ----------------------------------------------------------------------------
// tb_keyframe_track_sampler_core
// self-checking bench for the keyframe track sampler: directed rows on the
// search and ratio edges, then random tracks and queries under stalls
// ----------------------------------------------------------------------------
module tb_keyframe_track_sampler_core import kts_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS        = 64;
  localparam int ITEMS       = 500;
  localparam int SETTLE      = KEYS + 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TIME_W-1:0] Q_MARGIN = 24'h40;

  localparam logic [VEC_W-1:0] VEC_A = {32'h00000000, 32'h80000000, 32'h7FFFFFFF};
  localparam logic [VEC_W-1:0] VEC_B = {32'h00010000, 32'h7FFFFFFF, 32'h80000000};
  localparam logic [VEC_W-1:0] VEC_C = {32'h00000001, 32'hFFFF0000, 32'h12345678};
  localparam logic [VEC_W-1:0] VEC_D = {32'hFFFFFFFF, 32'h00000000, 32'hDEADBEEF};

  typedef enum logic [1:0] {ROW_KEY, ROW_QUERY, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CNT_W-1:0]  arg;
    logic [TIME_W-1:0] t;
    logic [VEC_W-1:0]  v;
    logic              fixed;
    logic [VEC_W-1:0]  want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [6:0]   cfg_wdata = '0;

  logic [TIME_W-1:0] track_time [KEYS];
  logic [VEC_W-1:0]  track_val [KEYS];
  logic [CNT_W-1:0]  key_count_reg = 7'd1;
  logic [VEC_W-1:0]  pending_values [$];

  stim_row_t dir_rows [24];
  int  items_sent = 0;
  int  mismatches = 0;
  int  cycle_cnt = 0;
  bit  quiet = 1'b0;

  always #2 clk = ~clk;

  keyframe_track_sampler_core #(.KEYS(KEYS)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // tdata: key_index, key_time, key_x, key_y, key_z, query_time, 2 zero bits
  function automatic logic [151:0] pack_item(input logic [5:0] slot,
                                             input logic [TIME_W-1:0] t,
                                             input logic [VEC_W-1:0] v,
                                             input logic [TIME_W-1:0] q);
    return {2'b00, q, v, t, slot};
  endfunction

  function automatic int keys_in_use();
    if (key_count_reg == 0) return 1;
    if (key_count_reg > KEYS) return KEYS;
    return int'(key_count_reg);
  endfunction

  function automatic logic [VEC_W-1:0] interpolate_track(input logic [TIME_W-1:0] q);
    int n;
    int seg;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [63:0] quot;
    logic [RATIO_W-1:0] ratio;
    longint e;
    longint l;
    longint v;
    logic [VEC_W-1:0] res;
    n = keys_in_use();
    if (n == 1) return track_val[0];
    seg = n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (q < track_time[i+1]) begin
        seg = i;
        break;
      end
    end
    t0 = track_time[seg];
    t1 = track_time[seg+1];
    if (t1 <= t0 || q <= t0) begin
      ratio = RATIO_ZERO;
    end else begin
      quot = 64'(q - t0) << FRAC_W;
      quot = quot / 64'(t1 - t0);
      ratio = (quot > 64'(RATIO_ONE)) ? RATIO_ONE : quot[RATIO_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      e = longint'(signed'(track_val[seg][c*COMP_W +: COMP_W]));
      l = longint'(signed'(track_val[seg+1][c*COMP_W +: COMP_W]));
      v = e + ((longint'(ratio) * (l - e)) >>> FRAC_W);
      res[c*COMP_W +: COMP_W] = COMP_W'(v);
    end
    return res;
  endfunction

  function automatic stim_row_t key_row(input logic [5:0] slot, input logic [TIME_W-1:0] t,
                                        input logic [VEC_W-1:0] v);
    return '{kind: ROW_KEY, arg: CNT_W'(slot), t: t, v: v, fixed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t query_row(input logic [TIME_W-1:0] q);
    return '{kind: ROW_QUERY, arg: '0, t: q, v: '0, fixed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t query_want(input logic [TIME_W-1:0] q,
                                           input logic [VEC_W-1:0] want);
    return '{kind: ROW_QUERY, arg: '0, t: q, v: '0, fixed: 1'b1, want: want};
  endfunction

  function automatic stim_row_t count_row(input logic [CNT_W-1:0] n);
    return '{kind: ROW_COUNT, arg: n, t: '0, v: '0, fixed: 1'b0, want: '0};
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec();
    logic [VEC_W-1:0] v;
    logic [COMP_W-1:0] edges [4];
    edges = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF};
    for (int c = 0; c < 3; c++) begin
      v[c*COMP_W +: COMP_W] = ($urandom_range(0, 7) == 0) ? edges[$urandom_range(0, 3)]
                                                           : COMP_W'($urandom);
    end
    return v;
  endfunction

  function automatic logic [TIME_W-1:0] step_time(input logic [TIME_W-1:0] t);
    int r;
    logic [TIME_W:0] sum;
    r = $urandom_range(0, 15);
    if (r == 0) sum = {1'b0, t};
    else if (r == 1) sum = {1'b0, t} + (TIME_W+1)'($urandom_range(0, 'h3FFFFF));
    else sum = {1'b0, t} + (TIME_W+1)'($urandom_range(1, 'h400));
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // one input transaction, predicted at the edge that accepts it
  task automatic push_item(input logic cmd, input logic [151:0] data, input logic fixed,
                           input logic [VEC_W-1:0] want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      track_time[data[5:0]] = data[29:6];
      track_val[data[5:0]]  = data[125:30];
    end else begin
      pending_values = {pending_values, (fixed ? want : interpolate_track(data[149:126]))};
    end
    if (items_sent >= ITEMS * 4 / 5) quiet = 1'b1;
  endtask

  task automatic rest_sender(input int pct);
    if (!quiet && $urandom_range(0, 99) < pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_count_reg = n;
  endtask

  task automatic run_phase(input int ph);
    logic [CNT_W-1:0] cnt;
    int n;
    int r;
    int idle_pct;
    int samples;
    bit unsorted;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] q;
    case (ph)
      0: cnt = 7'd64;
      1: cnt = 7'd127;
      2: cnt = 7'd1;
      3: cnt = 7'd0;
      default: begin
        r = $urandom_range(0, 31);
        if (r == 0) cnt = 7'd64;
        else if (r == 1) cnt = CNT_W'($urandom_range(65, 127));
        else if (r == 2) cnt = 7'd1;
        else cnt = CNT_W'($urandom_range(2, 8));
      end
    endcase
    set_count(cnt);
    n = keys_in_use();
    case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 20;
      default: idle_pct = 50;
    endcase
    unsorted = ($urandom_range(0, 9) == 0);
    t = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(0, 'hFFFF));
    for (int i = 0; i < n; i++) begin
      if (unsorted) t = TIME_W'($urandom);
      else if (i > 0) t = step_time(t);
      push_item(CMD_WRITE, pack_item(6'(i), t, rand_vec(), TIME_W'($urandom)), 1'b0, '0);
      rest_sender(idle_pct);
    end
    lo = track_time[0];
    hi = track_time[n-1];
    if (lo > hi) begin
      lo = track_time[n-1];
      hi = track_time[0];
    end
    lo = (lo > Q_MARGIN) ? lo - Q_MARGIN : '0;
    hi = (hi < TIME_MAX - Q_MARGIN) ? hi + Q_MARGIN : TIME_MAX;
    samples = $urandom_range(8, 30);
    for (int s = 0; s < samples; s++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(CMD_WRITE, pack_item(6'($urandom), TIME_W'($urandom), rand_vec(),
                                       TIME_W'($urandom)), 1'b0, '0);
      end else begin
        r = $urandom_range(0, 15);
        if (r == 0) q = '0;
        else if (r == 1) q = TIME_MAX;
        else if (r < 4) q = TIME_W'($urandom);
        else q = TIME_W'($urandom_range(lo, hi));
        push_item(CMD_SAMPLE, pack_item(6'($urandom), TIME_W'($urandom), rand_vec(), q),
                  1'b0, '0);
      end
      rest_sender(idle_pct);
    end
  endtask

  // output stalls
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 15) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    logic [VEC_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: %h", m_axis_tdata);
      end else begin
        want = pending_values.pop_front();
        if (want !== m_axis_tdata) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            if (want[31:0] !== m_axis_tdata[31:0])
              $display("value_x: expected %h got %h", want[31:0], m_axis_tdata[31:0]);
            if (want[63:32] !== m_axis_tdata[63:32])
              $display("value_y: expected %h got %h", want[63:32], m_axis_tdata[63:32]);
            if (want[95:64] !== m_axis_tdata[95:64])
              $display("value_z: expected %h got %h", want[95:64], m_axis_tdata[95:64]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int ph;
    ph = 0;
    dir_rows = '{
      key_row(6'd0, 'h000100, VEC_A),
      query_want('h000000, VEC_A),
      query_want('hFFFFFF, VEC_A),
      key_row(6'd1, 'h000300, VEC_B),
      count_row(7'd2),
      query_want('h000000, VEC_A),
      query_want('h000100, VEC_A),
      query_row('h000200),
      query_row('h0002FF),
      query_want('h000300, VEC_B),
      query_want('hFFFFFF, VEC_B),
      // equal times on the last segment
      key_row(6'd2, 'h000300, VEC_C),
      count_row(7'd3),
      query_want('h000400, VEC_B),
      query_want('h000300, VEC_B),
      // time going backwards
      key_row(6'd3, 'h000080, VEC_D),
      count_row(7'd4),
      query_want('h000350, VEC_C),
      query_want('h000000, VEC_A),
      count_row(7'd0),
      query_want('h123456, VEC_A),
      key_row(6'd63, 'hFFFFFF, VEC_D),
      count_row(7'd2),
      query_row('h000101)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        ROW_COUNT: set_count(dir_rows[k].arg);
        ROW_KEY: push_item(CMD_WRITE, pack_item(dir_rows[k].arg[5:0], dir_rows[k].t,
                                                dir_rows[k].v, TIME_W'($urandom)),
                           1'b0, '0);
        default: push_item(CMD_SAMPLE, pack_item(6'($urandom), TIME_W'($urandom),
                                                 rand_vec(), dir_rows[k].t),
                           dir_rows[k].fixed, dir_rows[k].want);
      endcase
      rest_sender(30);
    end
    while (items_sent < ITEMS) begin
      run_phase(ph);
      ph++;
    end
    drain();
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/kts_pkg.sv
rtl/kts_store.sv
rtl/kts_div.sv
rtl/kts_lerp.sv
rtl/keyframe_track_sampler_core.sv
bench/tb_keyframe_track_sampler_core.sv
